// File: sv/humidity_sensor_poll_controller_core_macros.svh
// Assertion macros used by the checker file of the poll controller.
`ifndef HUMIDITY_SENSOR_POLL_CONTROLLER_CORE_MACROS_SVH
`define HUMIDITY_SENSOR_POLL_CONTROLLER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HSPC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hspc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define HSPC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hspc assertion failed");

`endif

// File: sv/hspc_pkg.sv
// Shared types, codes and scaling constants of the humidity sensor poll controller.
`default_nettype none

package hspc_pkg;

    localparam int FRAME_W  = 48;
    localparam int RAW_W    = 20;
    localparam int HUM_W    = 14;
    localparam int TEMP_W   = 15;
    localparam int BUSY_BIT = 47;

    localparam logic [HUM_W-1:0]  HUM_SCALE   = 14'd10000;
    localparam logic [TEMP_W-1:0] TEMP_SCALE  = 15'd20000;
    localparam logic [TEMP_W-1:0] TEMP_OFFSET = 15'd5000;

    localparam logic [1:0] OP_TICK       = 2'd0;
    localparam logic [1:0] OP_FRAME      = 2'd1;
    localparam logic [1:0] OP_RESET_DONE = 2'd2;

    localparam logic [1:0] CMD_NONE    = 2'd0;
    localparam logic [1:0] CMD_READ    = 2'd1;
    localparam logic [1:0] CMD_MEASURE = 2'd2;
    localparam logic [1:0] CMD_RESET   = 2'd3;

    localparam logic [2:0] ADDR_ENABLE = 3'd0;
    localparam logic [2:0] ADDR_LIMIT  = 3'd4;

    localparam logic [7:0] ERR_LIMIT_RESET = 8'd5;
    localparam logic [7:0] ERR_COUNT_MAX   = 8'd255;

    typedef enum logic [2:0] {
        MODE_READY     = 3'b001,
        MODE_RECEIVING = 3'b010,
        MODE_RESETTING = 3'b100
    } mode_t;

    typedef struct packed {
        logic              busy;
        logic [HUM_W-1:0]  hum_centi;
        logic [TEMP_W-1:0] temp_centi;
    } decode_t;

endpackage

`default_nettype wire

// File: sv/hspc_decode.sv
// Frame decoder: busy bit and fixed-point scaling of raw humidity and temperature.
`default_nettype none

module hspc_decode (
    input  wire logic [hspc_pkg::FRAME_W-1:0] frame,
    output hspc_pkg::decode_t                 result
);
    import hspc_pkg::*;

    logic [RAW_W-1:0]        raw_h;
    logic [RAW_W-1:0]        raw_t;
    logic [RAW_W+HUM_W-1:0]  hum_prod;
    logic [RAW_W+TEMP_W-1:0] temp_prod;
    logic [TEMP_W-1:0]       temp_pos;

    assign raw_h     = frame[2*RAW_W-1:RAW_W];
    assign raw_t     = frame[RAW_W-1:0];
    assign hum_prod  = {{HUM_W{1'b0}}, raw_h} * {{RAW_W{1'b0}}, HUM_SCALE};
    assign temp_prod = {{TEMP_W{1'b0}}, raw_t} * {{RAW_W{1'b0}}, TEMP_SCALE};
    assign temp_pos  = temp_prod[RAW_W+TEMP_W-1:RAW_W];

    assign result.busy       = frame[BUSY_BIT];
    assign result.hum_centi  = hum_prod[RAW_W+HUM_W-1:RAW_W];
    assign result.temp_centi = temp_pos - TEMP_OFFSET;

endmodule

`default_nettype wire

// File: sv/humidity_sensor_poll_controller_core.sv
// Top level of the humidity sensor poll controller: event handling, mode control and result register.
//
//   Channel   Direction  Handshake         Payload
//   s_*       in         tvalid/tready     tuser: opcode; tdata: frame
//   m_*       out        tvalid/tready     tuser: command; tdata: decoded result
//   apb       in         psel/penable      enable at 0x0, error_limit at 0x4
//
// Each request is held in the input register, and any result it makes is registered in the
// output register; one request is taken every cycle while the output is not stalled. The mode
// and error count update as the request leaves the input register; the multipliers are combinational.
// Reset clears the mode to ready, the error count to zero and disables the block.
// A result held by a stalled output stops the input register, which then stops s_tready.
`default_nettype none

module humidity_sensor_poll_controller_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Fields from bit 0: opcode[1:0].
    input  wire logic [1:0]  s_tuser,
    // Fields from bit 0: frame[47:0].
    input  wire logic [47:0] s_tdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // Fields from bit 0: command[1:0].
    output logic [1:0]       m_tuser,
    // Fields from bit 0: frame_done, data_valid, humidity_centi[13:0],
    // temperature_centi[14:0], one zero pad bit.
    output logic [31:0]      m_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import hspc_pkg::*;

    logic              enable_reg;
    logic [7:0]        limit_reg;
    mode_t             mode_reg, mode_next;
    logic [7:0]        err_reg, err_next;
    logic [7:0]        err_inc;

    logic              in_valid_reg;
    logic [1:0]        in_op_reg;
    logic [FRAME_W-1:0] in_frame_reg;

    logic              out_valid_reg;
    logic [1:0]        out_cmd_reg;
    logic              out_done_reg;
    logic              out_dv_reg;
    logic [HUM_W-1:0]  out_hum_reg;
    logic [TEMP_W-1:0] out_temp_reg;

    decode_t           dec;
    logic              advance;
    logic              has_res;
    logic [1:0]        res_cmd;
    logic              res_done;
    logic              res_dv;
    logic              cfg_write;

    hspc_decode u_decode (
        .frame  (in_frame_reg),
        .result (dec)
    );

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = paddr[2] ? {24'd0, limit_reg} : {31'd0, enable_reg};

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign err_inc  = (err_reg == ERR_COUNT_MAX) ? err_reg : err_reg + 8'd1;

    always_comb
    begin
        mode_next = mode_reg;
        err_next  = err_reg;
        has_res   = 1'b0;
        res_cmd   = CMD_NONE;
        res_done  = 1'b0;
        res_dv    = 1'b0;
        if (enable_reg)
        begin
            unique case (in_op_reg)
                OP_TICK:
                begin
                    if (mode_reg == MODE_READY)
                    begin
                        mode_next = MODE_RECEIVING;
                        has_res   = 1'b1;
                        res_cmd   = CMD_READ;
                    end
                end
                OP_FRAME:
                begin
                    if (mode_reg == MODE_RECEIVING)
                    begin
                        has_res  = 1'b1;
                        res_done = 1'b1;
                        if (dec.busy)
                        begin
                            if (err_inc >= limit_reg)
                            begin
                                res_cmd   = CMD_RESET;
                                err_next  = 8'd0;
                                mode_next = MODE_RESETTING;
                            end
                            else
                            begin
                                err_next = err_inc;
                            end
                        end
                        else
                        begin
                            res_cmd   = CMD_MEASURE;
                            res_dv    = 1'b1;
                            err_next  = 8'd0;
                            mode_next = MODE_READY;
                        end
                    end
                end
                OP_RESET_DONE:
                begin
                    if (mode_reg == MODE_RESETTING)
                    begin
                        mode_next = MODE_READY;
                    end
                end
                default:
                begin
                    mode_next = mode_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= 1'b0;
            limit_reg     <= ERR_LIMIT_RESET;
            mode_reg      <= MODE_READY;
            err_reg       <= 8'd0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write && (paddr[2] == ADDR_ENABLE[2]))
            begin
                enable_reg <= pwdata[0];
            end
            if (cfg_write && (paddr[2] == ADDR_LIMIT[2]))
            begin
                limit_reg <= pwdata[7:0];
            end
            if (s_tvalid && s_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                mode_reg      <= mode_next;
                err_reg       <= err_next;
                out_valid_reg <= has_res;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_op_reg    <= s_tuser;
            in_frame_reg <= s_tdata;
        end
        if (advance && has_res)
        begin
            out_cmd_reg  <= res_cmd;
            out_done_reg <= res_done;
            out_dv_reg   <= res_dv;
            out_hum_reg  <= res_dv ? dec.hum_centi : '0;
            out_temp_reg <= res_dv ? dec.temp_centi : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_cmd_reg;
    assign m_tdata  = {1'b0, out_temp_reg, out_hum_reg, out_dv_reg, out_done_reg};

endmodule

`default_nettype wire

// File: sv/hspc_checker.sv
// Port-level checker of the humidity sensor poll controller and its bind.
`default_nettype none
`include "humidity_sensor_poll_controller_core_macros.svh"

module hspc_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic [1:0]  m_tuser,
    input wire logic [31:0] m_tdata,
    input wire logic        m_tvalid,
    input wire logic        m_tready
);
    import hspc_pkg::*;

    // A stalled result holds its payload.
    `HSPC_ASSERT_NXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // A valid reading always comes with the measure command, and only then.
    `HSPC_ASSERT_IMP(a_valid_measure, clk, rst_n, m_tvalid, (m_tuser == CMD_MEASURE) == m_tdata[1])

    // A result that reports no frame is a read start.
    `HSPC_ASSERT_IMP(a_tick_read, clk, rst_n, m_tvalid && !m_tdata[0], (m_tuser == CMD_READ) && !m_tdata[1])

    // Readings are zero unless the frame decoded cleanly.
    `HSPC_ASSERT_IMP(a_zero_readings, clk, rst_n, m_tvalid && !m_tdata[1], m_tdata[31:2] == 30'd0)

endmodule

bind humidity_sensor_poll_controller_core hspc_checker u_hspc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tuser  (m_tuser),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

`default_nettype wire
